[src/brpv_pkg.sv]
// Shared constants, codes and control types of the block request partition virtualizer.
package brpv_pkg;

    // Sizes. TRANSFER_BYTES and SECTOR_BYTES are powers of two.
    localparam int TAG_COUNT      = 1024;
    localparam int TRANSFER_BYTES = 4096;
    localparam int SECTOR_BYTES   = 512;

    localparam int TAG_W       = $clog2(TAG_COUNT);
    localparam int CNT_W       = $clog2(TAG_COUNT + 1);
    localparam int SPB         = (TRANSFER_BYTES / SECTOR_BYTES == 0) ? 1
                                 : TRANSFER_BYTES / SECTOR_BYTES;
    localparam int SPB_SHIFT   = $clog2(SPB);
    localparam int XFER_SHIFT  = $clog2(TRANSFER_BYTES);

    // Tag memory entry: in-use flag above the client tag.
    localparam int TAG_ENTRY_W = 33;

    // Beat layouts.
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 152;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic REQ_CLIENT   = 1'b0;
    localparam logic REQ_DRV_RESP = 1'b1;

    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_FLUSH   = 3'd2;
    localparam logic [2:0] OP_BARRIER = 3'd3;

    localparam logic [1:0] KIND_DRV_REQ     = 2'd0;
    localparam logic [1:0] KIND_CLIENT_RESP = 2'd1;
    localparam logic [1:0] KIND_BUSY        = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_INVAL = 2'd2;
    localparam logic [1:0] ST_RSVD  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PART_START  = 3'd0,
        CFG_PART_COUNT  = 3'd1,
        CFG_REGION_SIZE = 3'd2,
        CFG_BASE_PHYS   = 3'd3,
        CFG_BASE_VIRT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic clear;
        logic load;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;
        logic slot_free;
    } t_dp_sts;

endpackage

[src/brpv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module brpv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/brpv_ctrl.sv]
// Controller state machine: memory clearing pass, item accept and execute.
module brpv_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  brpv_pkg::t_dp_sts    i_sts,
    output brpv_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_in_ready
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_sts.clear_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  if (i_sts.slot_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.load   = r_ready && i_in_valid;
    assign o_cmd.commit = (r_state == S_EXEC) && i_sts.slot_free;
    assign o_in_ready   = r_ready;

endmodule

[src/brpv_datapath.sv]
// Datapath: configuration registers, request checks, tag pool memories, result register.
module brpv_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  brpv_pkg::t_ctrl_cmd                i_cmd,
    output brpv_pkg::t_dp_sts                  o_sts,
    input  logic                               i_cfg_valid,
    input  logic [brpv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [brpv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [brpv_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic                               i_in_user,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [brpv_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic [1:0]                         o_out_user
);

    localparam int TW = brpv_pkg::TAG_W;
    localparam int CW = brpv_pkg::CNT_W;
    localparam int XS = brpv_pkg::XFER_SHIFT;

    // Configuration.
    logic [31:0] r_part_start, r_part_count;
    logic [40:0] r_region_size;
    logic [47:0] r_base_phys, r_base_virt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_start  <= '0;
            r_part_count  <= '0;
            r_region_size <= '0;
            r_base_phys   <= '0;
            r_base_virt   <= '0;
        end else if (i_cfg_valid) begin
            case (brpv_pkg::t_cfg_idx'(i_cfg_index))
                brpv_pkg::CFG_PART_START:  r_part_start  <= i_cfg_data[31:0];
                brpv_pkg::CFG_PART_COUNT:  r_part_count  <= i_cfg_data[31:0];
                brpv_pkg::CFG_REGION_SIZE: r_region_size <= i_cfg_data[40:0];
                brpv_pkg::CFG_BASE_PHYS:   r_base_phys   <= i_cfg_data[47:0];
                brpv_pkg::CFG_BASE_VIRT:   r_base_virt   <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // Captured input beat.
    logic        r_type;
    logic [2:0]  r_op;
    logic [39:0] r_offset;
    logic [47:0] r_blkno;
    logic [15:0] r_count;
    logic [31:0] r_ctag;
    logic [1:0]  r_dstat;
    logic [15:0] r_done;
    logic [9:0]  r_dtag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type   <= i_in_user;
            r_op     <= i_in_data[2:0];
            r_offset <= i_in_data[42:3];
            r_blkno  <= i_in_data[90:43];
            r_count  <= i_in_data[106:91];
            r_ctag   <= i_in_data[138:107];
            r_dstat  <= i_in_data[140:139];
            r_done   <= i_in_data[156:141];
            r_dtag   <= i_in_data[166:157];
        end
    end

    // Free-tag count and clearing sweep index.
    logic [CW-1:0] r_free_cnt, n_free_cnt;
    logic [TW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + TW'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_idx == TW'(brpv_pkg::TAG_COUNT - 1));

    // Memories.
    logic                               tag_we, stk_we;
    logic [TW-1:0]                      tag_waddr, stk_waddr, stk_wdata;
    logic [brpv_pkg::TAG_ENTRY_W-1:0]   tag_wdata, tag_rdata;
    logic [TW-1:0]                      stk_rdata;

    brpv_ram #(
        .WIDTH(brpv_pkg::TAG_ENTRY_W),
        .DEPTH(brpv_pkg::TAG_COUNT)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (tag_we),
        .i_waddr(tag_waddr),
        .i_wdata(tag_wdata),
        .i_re   (i_cmd.load),
        .i_raddr(TW'(i_in_data[166:157])),
        .o_rdata(tag_rdata)
    );

    brpv_ram #(
        .WIDTH(TW),
        .DEPTH(brpv_pkg::TAG_COUNT)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_re   (i_cmd.load),
        .i_raddr(r_free_cnt[TW-1:0] - TW'(1)),
        .o_rdata(stk_rdata)
    );

    // Request checks on the captured beat.
    logic [31:0] pstart, plen;
    logic [48:0] dblk;
    logic [47:0] dma;
    logic        bound_ok, region_ok, align_ok, req_ok;
    logic [XS-1:0] align_sum;
    logic        tag_known, pool_empty;
    logic [1:0]  drv_st;

    assign pstart    = r_part_start >> brpv_pkg::SPB_SHIFT;
    assign plen      = r_part_count >> brpv_pkg::SPB_SHIFT;
    assign dblk      = {1'b0, r_blkno} + 49'(pstart);
    assign dma       = r_base_phys + 48'(r_offset);
    assign bound_ok  = (50'(dblk) + 50'(r_count)) <= (50'(pstart) + 50'(plen));
    assign region_ok = (42'(r_offset) + (42'(r_count) << XS)) <= 42'(r_region_size);
    assign align_sum = r_base_virt[XS-1:0] + r_offset[XS-1:0];
    assign align_ok  = (align_sum == '0);

    always_comb begin
        if (r_op > brpv_pkg::OP_BARRIER) begin
            req_ok = 1'b0;
        end else if (r_op == brpv_pkg::OP_READ || r_op == brpv_pkg::OP_WRITE) begin
            req_ok = bound_ok && region_ok && align_ok && (r_count != '0);
        end else begin
            req_ok = 1'b1;
        end
    end

    assign pool_empty = (r_free_cnt == '0);
    assign tag_known  = (int'(r_dtag) < brpv_pkg::TAG_COUNT)
                        && tag_rdata[brpv_pkg::TAG_ENTRY_W-1];
    assign drv_st     = (r_dstat == brpv_pkg::ST_RSVD) ? brpv_pkg::ST_ERR : r_dstat;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [1:0]  r_code, n_code;
    logic [47:0] r_dma, n_dma;
    logic [48:0] r_dblk, n_dblk;
    logic [15:0] r_ocount, n_ocount;
    logic [31:0] r_otag, n_otag;
    logic [1:0]  r_status, n_status;
    logic        has_result;

    always_comb begin
        tag_we     = 1'b0;
        tag_waddr  = r_clr_idx;
        tag_wdata  = '0;
        stk_we     = 1'b0;
        stk_waddr  = r_clr_idx;
        stk_wdata  = TW'(brpv_pkg::TAG_COUNT - 1) - r_clr_idx;
        n_free_cnt = r_free_cnt;
        has_result = 1'b0;
        n_kind     = brpv_pkg::KIND_CLIENT_RESP;
        n_code     = '0;
        n_dma      = '0;
        n_dblk     = '0;
        n_ocount   = '0;
        n_otag     = r_ctag;
        n_status   = brpv_pkg::ST_OK;

        if (i_cmd.clear) begin
            // Sweep: mark every tag free and lay out the stack so tag 0 pops first.
            tag_we = 1'b1;
            stk_we = 1'b1;
        end else if (i_cmd.commit) begin
            if (r_type == brpv_pkg::REQ_DRV_RESP) begin
                if (tag_known) begin
                    has_result = 1'b1;
                    tag_we     = 1'b1;
                    tag_waddr  = TW'(r_dtag);
                    tag_wdata  = '0;
                    if (int'(r_free_cnt) < brpv_pkg::TAG_COUNT) begin
                        stk_we     = 1'b1;
                        stk_waddr  = r_free_cnt[TW-1:0];
                        stk_wdata  = TW'(r_dtag);
                        n_free_cnt = r_free_cnt + CW'(1);
                    end
                    n_ocount = r_done;
                    n_otag   = tag_rdata[31:0];
                    n_status = drv_st;
                end
            end else if (pool_empty) begin
                has_result = 1'b1;
                n_kind     = brpv_pkg::KIND_BUSY;
            end else if (!req_ok) begin
                has_result = 1'b1;
                n_status   = brpv_pkg::ST_INVAL;
            end else begin
                has_result = 1'b1;
                tag_we     = 1'b1;
                tag_waddr  = stk_rdata;
                tag_wdata  = {1'b1, r_ctag};
                n_free_cnt = r_free_cnt - CW'(1);
                n_kind     = brpv_pkg::KIND_DRV_REQ;
                n_code     = r_op[1:0];
                n_dma      = dma;
                n_dblk     = dblk;
                n_ocount   = r_count;
                n_otag     = 32'(stk_rdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt  <= CW'(brpv_pkg::TAG_COUNT);
            r_out_valid <= 1'b0;
        end else begin
            r_free_cnt <= n_free_cnt;
            if (i_cmd.commit && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && has_result) begin
            r_kind   <= n_kind;
            r_code   <= n_code;
            r_dma    <= n_dma;
            r_dblk   <= n_dblk;
            r_ocount <= n_ocount;
            r_otag   <= n_otag;
            r_status <= n_status;
        end
    end

    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_user      = r_kind;
    assign o_out_data      = {3'b000, r_status, r_otag, r_ocount, r_dblk, r_dma, r_code};

endmodule

[src/block_request_partition_virtualizer_core.sv]
// Top level of the block request partition virtualizer.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: client request or driver response
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: driver request or client response
// cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// Each item has an accept cycle, which issues the reads of the tag memory and the free-tag
// stack, and an execute cycle, which checks, updates the memories and loads any result.
// After reset a clearing pass over all TAG_COUNT (1024) entries initializes both memories; no item
// is accepted during it, while configuration writes are always taken.
// A full result register that is not drained holds the execute cycle until it frees.
module block_request_partition_virtualizer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // op_code[2:0], data_offset[42:3], block_number[90:43], block_count[106:91],
    // client_tag[138:107], drv_result[140:139], drv_done_count[156:141],
    // drv_tag[166:157], zero pad[167]
    input  logic [brpv_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_code[1:0], dma_address[49:2], device_block[98:50], out_count[114:99],
    // out_tag[146:115], status_code[148:147], zero pad[151:149]
    output logic [brpv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // out_kind[1:0]
    output logic [1:0]                         m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [brpv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [brpv_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    brpv_pkg::t_ctrl_cmd cmd;
    brpv_pkg::t_dp_sts   sts;

    assign o_cfg_ready = 1'b1;

    brpv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_in_ready(s_axis_tready)
    );

    brpv_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (s_axis_tdata),
        .i_in_user  (s_axis_tuser),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_out_data (m_axis_tdata),
        .o_out_user (m_axis_tuser)
    );

`ifndef ASSERT_OFF
    // No item may enter while the memories are still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !s_axis_tready)
        else $error("input ready during clearing pass");

    // One item at a time: an accepted beat is followed by an execute cycle.
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready in the cycle after an accept");

    // A result only appears as the product of an execute cycle.
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.commit))
        else $error("result valid without a commit");
`endif

endmodule
